@@ hdl/bltc_pkg.sv @@
// Shared constants, command codes and control types of the block tag LRU cache.
`default_nettype none

package bltc_pkg;

    // Fixed widths of the transaction fields.
    localparam int CMD_W      = 2;
    localparam int LEVEL_W    = 4;
    localparam int INDEX_W    = 12;
    localparam int SEL_W      = 4;
    localparam int SLOT_OUT_W = 4;
    localparam int STAMP_W    = 32;

    // Default configuration of the tag store.
    localparam int DEF_SLOTS      = 16;
    localparam int DEF_LEVEL_BITS = 4;
    localparam int DEF_INDEX_BITS = 12;

    // Command codes; code 3 is unused and produces an all-zero result.
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLAIM  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan;
        logic commit;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ hdl/bltc_ifs.sv @@
// Request and response channel interfaces of the block tag LRU cache.
`default_nettype none

interface bltc_req_if import bltc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [LEVEL_W-1:0]   level;
    logic [INDEX_W-1:0]   block_x;
    logic [INDEX_W-1:0]   block_y;
    logic [SEL_W-1:0]     slot_index;

    modport source (output valid, command, level, block_x, block_y, slot_index,
                    input ready);
    modport sink   (input valid, command, level, block_x, block_y, slot_index,
                    output ready);
endinterface

interface bltc_rsp_if import bltc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;

    modport source (output valid, hit, slot, evicted, input ready);
    modport sink   (input valid, hit, slot, evicted, output ready);
endinterface

`default_nettype wire

@@ hdl/block_tag_lru_cache_core.sv @@
// Top level of the block tag LRU cache: controller and datapath.
// The block is a fully associative tag store with least recently used
// replacement by 32-bit timestamps, held in a SLOTS-entry tag memory.
// Requests arrive on i_req as valid/ready transactions carrying a command
// (lookup, claim or invalidate), a key of level, block column and block row,
// and a slot index for invalidation. Each request gives exactly one
// response transaction on o_rsp with hit, slot and evicted.
// Lookup and claim walk the tag memory one entry per cycle through its
// single registered read port. Such a request steps through accept, a read
// of each of the SLOTS entries in turn, a drain step that compares the last
// entry and a commit step that loads the response register; only then is a
// new request taken.
// Invalidate and the unused command need no scan and go from accept to commit.
// The response sits in an output register, so the next request is taken and
// scanned while the previous response still waits; if the receiver stalls,
// the block holds the finished request at its commit step until the output
// register is free, and accepts nothing more meanwhile.
// Reset clears all valid marks, the use counter and the response register;
// the tag memory itself is not cleared, since an entry is only ever read
// as a match or eviction candidate once it has been written.
`default_nettype none

module block_tag_lru_cache_core import bltc_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int LEVEL_BITS = DEF_LEVEL_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bltc_req_if.sink   i_req,
    bltc_rsp_if.source o_rsp
);

    t_dp_ctl    w_ctl;
    t_dp_status w_status;
    logic       w_req_ready;

    assign i_req.ready = w_req_ready;

    // The controller sequences accept, scan and commit; it sees no payload.
    bltc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (w_status),
        .o_req_ready (w_req_ready),
        .o_ctl       (w_ctl)
    );

    // The datapath holds the tags, valid marks, stamps and the response.
    bltc_dp #(
        .SLOTS      (SLOTS),
        .LEVEL_BITS (LEVEL_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_status     (w_status),
        .i_command    (i_req.command),
        .i_level      (i_req.level),
        .i_block_x    (i_req.block_x),
        .i_block_y    (i_req.block_y),
        .i_slot_index (i_req.slot_index),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_hit        (o_rsp.hit),
        .o_slot       (o_rsp.slot),
        .o_evicted    (o_rsp.evicted)
    );

endmodule

`default_nettype wire

@@ hdl/bltc_ctrl.sv @@
// Sequencing state machine of the block tag LRU cache.
`default_nettype none

module bltc_ctrl import bltc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    input  wire t_dp_status i_status,
    output logic            o_req_ready,
    output t_dp_ctl         o_ctl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    t_state r_state;

    always_comb begin
        o_req_ready   = (r_state == ST_IDLE);
        o_ctl.accept  = (r_state == ST_IDLE) && i_req_valid;
        o_ctl.scan    = (r_state == ST_SCAN);
        o_ctl.commit  = (r_state == ST_COMMIT) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req_valid) begin
                        r_state <= i_status.need_scan ? ST_SCAN : ST_COMMIT;
                    end
                end
                ST_SCAN: begin
                    if (i_status.scan_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (i_status.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // A finished result waits in COMMIT until the output register is free.
    a_commit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT && !i_status.out_free) |=> (r_state == ST_COMMIT))
        else $error("commit left while the output register was occupied");

    // Commands without a scan go straight to the commit step.
    a_no_scan_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.accept && !i_status.need_scan) |=> (r_state == ST_COMMIT))
        else $error("invalidate or unknown command did not go to commit");

endmodule

`default_nettype wire

@@ hdl/bltc_dp.sv @@
// Tag memory, scan comparators, use counter and result register of the cache.
`default_nettype none

module bltc_dp import bltc_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int LEVEL_BITS = DEF_LEVEL_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_ctl               i_ctl,
    output t_dp_status                 o_status,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [LEVEL_W-1:0]    i_level,
    input  wire logic [INDEX_W-1:0]    i_block_x,
    input  wire logic [INDEX_W-1:0]    i_block_y,
    input  wire logic [SEL_W-1:0]      i_slot_index,
    input  wire logic                  i_rsp_ready,
    output logic                       o_rsp_valid,
    output logic                       o_hit,
    output logic [SLOT_OUT_W-1:0]      o_slot,
    output logic                       o_evicted
);

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KEY_W     = LEVEL_BITS + 2 * INDEX_BITS;
    localparam int ENTRY_W   = KEY_W + STAMP_W;
    localparam int SEL_CMP_W = 8;

    // Key of the incoming request, cut or zero-extended to the stored widths.
    logic [LEVEL_BITS-1:0] w_key_lvl;
    logic [INDEX_BITS-1:0] w_key_x;
    logic [INDEX_BITS-1:0] w_key_y;

    genvar gb;
    generate
        for (gb = 0; gb < LEVEL_BITS; gb++) begin : g_lvl
            if (gb < LEVEL_W) begin : g_in
                assign w_key_lvl[gb] = i_level[gb];
            end else begin : g_zero
                assign w_key_lvl[gb] = 1'b0;
            end
        end
        for (gb = 0; gb < INDEX_BITS; gb++) begin : g_idx
            if (gb < INDEX_W) begin : g_in
                assign w_key_x[gb] = i_block_x[gb];
                assign w_key_y[gb] = i_block_y[gb];
            end else begin : g_zero
                assign w_key_x[gb] = 1'b0;
                assign w_key_y[gb] = 1'b0;
            end
        end
    endgenerate

    // Entry layout: key in the upper bits, stamp in the lower bits.
    logic [ENTRY_W-1:0]    r_mem [SLOTS];
    logic [SLOTS-1:0]      r_valid;
    logic [STAMP_W-1:0]    r_use_cnt;
    logic [STAMP_W-1:0]    n_use_cnt;

    // Captured request.
    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_W-1:0]      r_key;
    logic [SEL_W-1:0]      r_sel;

    // Scan pipeline and search trackers.
    logic [SLOT_W-1:0]     r_addr;
    logic [ENTRY_W-1:0]    r_rd_data;
    logic [SLOT_W-1:0]     r_rd_idx;
    logic                  r_rd_vld;
    logic                  r_found;
    logic [SLOT_W-1:0]     r_best;
    logic                  r_free;
    logic [SLOT_W-1:0]     r_free_idx;
    logic [STAMP_W-1:0]    r_min;
    logic [SLOT_W-1:0]     r_min_idx;

    // Result register.
    logic                  r_out_valid;
    logic                  r_hit;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic                  r_evicted;

    // Commit decision.
    logic [SLOT_W-1:0]     w_victim;
    logic [SLOT_W-1:0]     w_sel_idx;
    logic                  w_sel_ok;
    logic                  w_we;
    logic [SLOT_W-1:0]     w_waddr;
    logic                  w_set_valid;
    logic                  w_clr_valid;
    logic                  w_hit;
    logic [SLOT_OUT_W-1:0] w_slot;
    logic                  w_evicted;

    logic [KEY_W-1:0]      w_rd_key;
    logic [STAMP_W-1:0]    w_rd_stamp;
    logic                  w_rd_slot_valid;

    assign n_use_cnt       = STAMP_W'(r_use_cnt + 32'd1);
    assign w_rd_key        = r_rd_data[ENTRY_W-1:STAMP_W];
    assign w_rd_stamp      = r_rd_data[STAMP_W-1:0];
    assign w_rd_slot_valid = r_valid[r_rd_idx];

    assign w_victim  = r_free ? r_free_idx : r_min_idx;
    assign w_sel_idx = SLOT_W'(r_sel);
    assign w_sel_ok  = (SEL_CMP_W'(r_sel) < SEL_CMP_W'(SLOTS));

    always_comb begin
        w_we        = 1'b0;
        w_waddr     = w_victim;
        w_set_valid = 1'b0;
        w_clr_valid = 1'b0;
        w_hit       = 1'b0;
        w_slot      = '0;
        w_evicted   = 1'b0;
        unique case (r_cmd)
            CMD_LOOKUP: begin
                if (r_found) begin
                    w_we    = 1'b1;
                    w_waddr = r_best;
                    w_hit   = 1'b1;
                    w_slot  = SLOT_OUT_W'(r_best);
                end
            end
            CMD_CLAIM: begin
                w_we        = 1'b1;
                w_set_valid = 1'b1;
                w_slot      = SLOT_OUT_W'(w_victim);
                w_evicted   = !r_free;
            end
            CMD_INVAL: begin
                w_clr_valid = w_sel_ok;
                w_slot      = SLOT_OUT_W'(r_sel);
            end
            default: begin
            end
        endcase
    end

    assign o_status.need_scan = (i_command == CMD_LOOKUP) || (i_command == CMD_CLAIM);
    assign o_status.scan_last = (r_addr == SLOT_W'(SLOTS - 1));
    assign o_status.out_free  = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_slot      = r_slot;
    assign o_evicted   = r_evicted;

    // Tag memory: one write port at commit, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && w_we) begin
            r_mem[w_waddr] <= {r_key, n_use_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_use_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_rd_vld <= i_ctl.scan;
            if (i_ctl.commit) begin
                r_out_valid <= 1'b1;
                if (w_we) begin
                    r_use_cnt <= n_use_cnt;
                end
                if (w_set_valid) begin
                    r_valid[w_waddr] <= 1'b1;
                end
                if (w_clr_valid) begin
                    r_valid[w_sel_idx] <= 1'b0;
                end
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, scan trackers and result payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd   <= i_command;
            r_key   <= {w_key_lvl, w_key_x, w_key_y};
            r_sel   <= i_slot_index;
            r_addr  <= '0;
            r_found <= 1'b0;
            r_free  <= 1'b0;
        end
        if (i_ctl.scan) begin
            r_rd_idx <= r_addr;
            r_addr   <= SLOT_W'(r_addr + 1'b1);
        end
        if (r_rd_vld) begin
            if (!r_found && w_rd_slot_valid && (w_rd_key == r_key)) begin
                r_found <= 1'b1;
                r_best  <= r_rd_idx;
            end
            if (!r_free && !w_rd_slot_valid) begin
                r_free     <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            // Strict compare keeps the lowest index among equal stamps.
            if ((r_rd_idx == '0) || (w_rd_stamp < r_min)) begin
                r_min     <= w_rd_stamp;
                r_min_idx <= r_rd_idx;
            end
        end
        if (i_ctl.commit) begin
            r_hit     <= w_hit;
            r_slot    <= w_slot;
            r_evicted <= w_evicted;
        end
    end

    // A claimed slot is valid straight after the commit.
    a_claim_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.commit && r_cmd == CMD_CLAIM) |=> r_valid[$past(w_victim)])
        else $error("claimed slot not marked valid");

    // The use counter only moves when a stamp is written.
    a_counter_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.commit |=> $stable(r_use_cnt))
        else $error("use counter changed outside a commit");

endmodule

`default_nettype wire
